[rtl/nzwa_pkg.sv]
// ----------------------------------------------------------------------------
// nzwa_pkg
// Shared constants for the non-zero window average block: window length and
// the widths of the sample, running sum, non-zero count and divider counter.
// ----------------------------------------------------------------------------
package nzwa_pkg;

    // Number of samples held in the window (2 .. 256)
    localparam int WINDOW   = 8;

    // Range reading width; the mean of such readings fits the same width
    localparam int SAMPLE_W = 16;

    // Running sum of up to WINDOW readings
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);

    // Count of non-zero readings, 0 .. WINDOW
    localparam int CNT_W    = $clog2(WINDOW + 1);

    // Divider step counter, one quotient bit per step
    localparam int STEP_W   = $clog2(SAMPLE_W);

endpackage

[rtl/nonzero_window_average_top.sv]
// ----------------------------------------------------------------------------
// nonzero_window_average_top
// Mean of the non-zero range readings over the last WINDOW samples; zero
// readings mean no echo and are left out. Empty window gives zero and a flag.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  input     in         i_valid / o_stall  i_sample
//  result    out        o_valid / i_stall  o_average, o_empty_res
//
//  A transaction runs from acceptance to the result register in order:
//  load the divider, SAMPLE_W steps of the restoring divider, see the
//  divider finish, write the result. The delay line, sum and count
//  advance at the accepting edge itself. The next transaction is taken
//  only after the result is written. The divider is the only iterative
//  unit.
//  Reset (synchronous, active low) clears the window, sum, count and control.
//  A new transaction is accepted while a finished result still waits; the
//  next result waits for the output register to drain under i_stall.
// ----------------------------------------------------------------------------
module nonzero_window_average_top
    import nzwa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [SAMPLE_W-1:0] o_average,
    output logic                o_empty_res
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [SAMPLE_W-1:0] r_average;
    logic [SAMPLE_W-1:0] n_average;
    logic                r_empty;
    logic                n_empty;

    logic                accept;
    logic                out_free;
    logic                div_done;
    logic [SAMPLE_W-1:0] quotient;
    logic [SAMPLE_W-1:0] tap [WINDOW+1];

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    // Delay line: newest reading enters at the head, oldest leaves at the tail
    assign tap[0] = i_sample;

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        nzwa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (accept),
            .i_data  (tap[g]),
            .o_data  (tap[g+1])
        );
    end

    // Drop the outgoing reading and add the incoming one
    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        if (accept) begin
            n_sum = r_sum + SUM_W'(i_sample) - SUM_W'(tap[WINDOW]);
            n_cnt = r_cnt + CNT_W'(i_sample != '0) - CNT_W'(tap[WINDOW] != '0);
        end
    end

    nzwa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_LOAD),
        .i_dividend (r_sum),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Sequence one transaction through the divider and into the result register
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_stall;
        n_average   = r_average;
        n_empty     = r_empty;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_empty     = (r_cnt == '0);
                    n_average   = (r_cnt == '0) ? '0 : quotient;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge i_clk) begin
        r_average <= n_average;
        r_empty   <= n_empty;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_average   = r_average;
    assign o_empty_res = r_empty;

endmodule

[rtl/nzwa_cell.sv]
// ----------------------------------------------------------------------------
// nzwa_cell
// One stage of the sample delay line. Holds one reading and takes its
// neighbour's reading whenever the line advances.
// ----------------------------------------------------------------------------
module nzwa_cell
    import nzwa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  logic [SAMPLE_W-1:0] i_data,
    output logic [SAMPLE_W-1:0] o_data
);

    logic [SAMPLE_W-1:0] r_data;
    logic [SAMPLE_W-1:0] n_data;

    // Take the younger neighbour's reading on advance, otherwise hold
    always_comb begin
        n_data = r_data;
        if (i_shift) begin
            n_data = i_data;
        end
    end

    // Window starts out as all zeros (no echo)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

[rtl/nzwa_div.sv]
// ----------------------------------------------------------------------------
// nzwa_div
// Restoring divider for the window mean: one quotient bit per cycle, giving
// floor(sum / count) over SAMPLE_W steps after a start pulse.
// ----------------------------------------------------------------------------
module nzwa_div
    import nzwa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SUM_W-1:0]    i_dividend,
    input  logic [CNT_W-1:0]    i_divisor,
    output logic                o_done,
    output logic [SAMPLE_W-1:0] o_quotient
);

    logic                r_busy;
    logic                n_busy;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;
    logic [CNT_W-1:0]    r_rem;
    logic [CNT_W-1:0]    n_rem;
    logic [SAMPLE_W-1:0] r_quo;
    logic [SAMPLE_W-1:0] n_quo;
    logic [CNT_W-1:0]    r_div;
    logic [CNT_W-1:0]    n_div;
    logic                r_done;
    logic                n_done;
    logic [CNT_W:0]      trial;
    logic                fits;

    // Partial remainder with the next dividend bit brought down
    assign trial = {r_rem, r_quo[SAMPLE_W-1]};
    assign fits  = (trial >= (CNT_W + 1)'(r_div));

    // Load on start, then shift one quotient bit in per cycle.
    // The quotient fits SAMPLE_W bits, so the bits above it seed the remainder.
    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(SAMPLE_W - 1);
            n_rem  = CNT_W'(i_dividend >> SAMPLE_W);
            n_quo  = i_dividend[SAMPLE_W-1:0];
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (fits) begin
                n_rem = CNT_W'(trial - (CNT_W + 1)'(r_div));
            end else begin
                n_rem = CNT_W'(trial);
            end
            n_quo = {r_quo[SAMPLE_W-2:0], fits};
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_step = r_step - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    // Datapath registers need no reset
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
